[sv/ppr_pkg.sv]
// Package for the pulse period ratio converter: register indexes, field widths
// and reset values shared by the interfaces and the core.
// No dependencies.
`timescale 1ns / 1ps

package ppr_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BASE_RATIO   = 2'd0,
		CFG_OFFSET_TRIM  = 2'd1,
		CFG_STOP_TIMEOUT = 2'd2,
		CFG_INPUT_LIMIT  = 2'd3
	} cfg_idx_t;

	localparam int RATIO_W   = 10;
	localparam int TRIM_W    = 10;
	localparam int TIMEOUT_W = 16;
	localparam int CAPTURE_W = 15;
	localparam int COUNT_W   = 16;
	// base + trim spans -512..1534: 12 bits signed, 11 bits once clamped positive
	localparam int FACTOR_SW = 12;
	localparam int FACTOR_W  = 11;

	typedef logic [RATIO_W-1:0]   ratio_t;
	typedef logic [TRIM_W-1:0]    trim_t;
	typedef logic [TIMEOUT_W-1:0] timeout_t;
	typedef logic [CAPTURE_W-1:0] capture_t;
	typedef logic [COUNT_W-1:0]   count_t;

	localparam ratio_t   RST_BASE_RATIO   = 10'd601;
	localparam trim_t    RST_OFFSET_TRIM  = 10'd0;
	localparam timeout_t RST_STOP_TIMEOUT = 16'd32768;
	localparam capture_t RST_INPUT_LIMIT  = 15'd13952;

	localparam capture_t CAPTURE_MAX = {CAPTURE_W{1'b1}};
	localparam count_t   COUNT_MAX   = {COUNT_W{1'b1}};

endpackage

[sv/ppr_if.sv]
// Valid/ready channels of the pulse period ratio converter: one tick in, one
// result out. Depends on ppr_pkg for the field widths.
`timescale 1ns / 1ps

interface ppr_in_if import ppr_pkg::*; ();
	logic valid;
	logic ready;
	logic sensor_level;

	modport source (output valid, output sensor_level, input ready);
	modport sink   (input valid, input sensor_level, output ready);
endinterface

interface ppr_out_if import ppr_pkg::*; ();
	logic     valid;
	logic     ready;
	logic     pulse_out;
	logic     running;
	capture_t measured_period;

	modport source (output valid, output pulse_out, output running,
		output measured_period, input ready);
	modport sink   (input valid, input pulse_out, input running,
		input measured_period, output ready);
endinterface

[sv/pulse_period_ratio_converter_core.sv]
// Pulse period ratio converter: each input beat is one microsecond tick of the
// wheel sensor level; the block measures falling-edge periods and drives a
// scaled square wave. The core takes one tick per clock cycle: the period
// measurement, the single scaling multiply and the wave update all happen in
// the cycle a beat is accepted, and the result is captured in the output
// register at the end of that cycle. A new beat is taken every cycle unless
// the output register still holds a result not yet taken. Configuration
// writes are registered and should only be made while no tick is in flight.
// Depends on ppr_pkg and ppr_if.
`timescale 1ns / 1ps

module pulse_period_ratio_converter_core import ppr_pkg::*; #(
	parameter int RATIO_FRACTION_BITS = 8,
	parameter int PERIOD_WIDTH        = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	ppr_in_if.sink                in_ch,
	ppr_out_if.source             out_ch,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int PROD_W = CAPTURE_W + FACTOR_W;

	typedef logic [PERIOD_WIDTH-1:0] period_t;

	localparam period_t RST_ACTIVE_PERIOD = period_t'(10);
	localparam period_t RST_ACTIVE_HIGH   = period_t'(5);

	// configuration
	ratio_t   base_ratio_q;
	trim_t    offset_trim_q;
	timeout_t stop_timeout_q;
	capture_t input_limit_q;

	// measurement and wave state
	count_t   period_count_q;
	capture_t captured_period_q;
	capture_t applied_capture_q;
	count_t   idle_ticks_q;
	logic     overlong_q;
	logic     prev_level_q;
	period_t  active_period_q;
	period_t  active_high_q;
	period_t  pending_period_q;
	period_t  pending_high_q;
	logic     pending_valid_q;
	period_t  wave_count_q;

	// output register
	logic     out_valid_q;
	logic     pulse_q;
	logic     running_q;
	capture_t measured_q;

	logic accept;
	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign accept      = in_ch.valid && in_ch.ready;

	// ---- measurement ----
	logic     fall;
	count_t   cnt;
	capture_t cap_next;
	count_t   count_next;
	count_t   idle_next;
	logic     overlong_next;
	logic     stopped;

	always_comb begin
		fall = prev_level_q && !in_ch.sensor_level;
		cnt  = (period_count_q == COUNT_MAX) ? COUNT_MAX : period_count_q + count_t'(1);
		cap_next      = captured_period_q;
		count_next    = cnt;
		idle_next     = idle_ticks_q;
		overlong_next = overlong_q;
		if (fall) begin
			cap_next      = (cnt > count_t'(CAPTURE_MAX)) ? CAPTURE_MAX : cnt[CAPTURE_W-1:0];
			count_next    = '0;
			idle_next     = '0;
			overlong_next = 1'b0;
		end else begin
			if (cnt > count_t'(CAPTURE_MAX)) begin
				overlong_next = 1'b1;
			end
			if (idle_ticks_q != COUNT_MAX) begin
				idle_next = idle_ticks_q + count_t'(1);
			end
		end
		stopped = (idle_next >= stop_timeout_q) || overlong_next ||
			(cap_next >= input_limit_q);
	end

	// ---- scaling ----
	logic signed [FACTOR_SW-1:0] factor_s;
	logic [FACTOR_W-1:0]         factor;
	logic [PROD_W-1:0]           product;
	logic [PROD_W-1:0]           shifted;
	period_t                     scaled;
	logic [PERIOD_WIDTH:0]       scaled_inc;

	always_comb begin
		factor_s = $signed({2'b00, base_ratio_q}) +
			$signed({{(FACTOR_SW-TRIM_W){offset_trim_q[TRIM_W-1]}}, offset_trim_q});
		factor   = (factor_s < $signed(FACTOR_SW'(1))) ? FACTOR_W'(1)
			: factor_s[FACTOR_W-1:0];
		product  = PROD_W'(cap_next) * PROD_W'(factor);
		shifted  = product >> RATIO_FRACTION_BITS;
		// clip at the widest period the wave counter can run
		scaled   = (|(shifted >> PERIOD_WIDTH)) ? {PERIOD_WIDTH{1'b1}}
			: shifted[PERIOD_WIDTH-1:0];
		scaled_inc = {1'b0, scaled} + (PERIOD_WIDTH+1)'(1);
	end

	// ---- wave ----
	logic    rescale;
	logic    pend_valid_n;
	period_t pend_period_n;
	period_t pend_high_n;
	logic    wrap;
	logic    pulse_n;

	always_comb begin
		rescale       = !stopped && (applied_capture_q != cap_next);
		pend_valid_n  = pending_valid_q;
		pend_period_n = pending_period_q;
		pend_high_n   = pending_high_q;
		// periods of 0 or 1 tick are dropped
		if (rescale && scaled > period_t'(1)) begin
			pend_valid_n  = 1'b1;
			pend_period_n = scaled;
			pend_high_n   = scaled_inc[PERIOD_WIDTH:1];
		end
		pulse_n = !stopped && (wave_count_q < active_high_q);
		wrap    = ({1'b0, wave_count_q} + (PERIOD_WIDTH+1)'(1)) >= {1'b0, active_period_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_ratio_q   <= RST_BASE_RATIO;
			offset_trim_q  <= RST_OFFSET_TRIM;
			stop_timeout_q <= RST_STOP_TIMEOUT;
			input_limit_q  <= RST_INPUT_LIMIT;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_BASE_RATIO:   base_ratio_q   <= cfg_data[RATIO_W-1:0];
				CFG_OFFSET_TRIM:  offset_trim_q  <= cfg_data[TRIM_W-1:0];
				CFG_STOP_TIMEOUT: stop_timeout_q <= cfg_data[TIMEOUT_W-1:0];
				CFG_INPUT_LIMIT:  input_limit_q  <= cfg_data[CAPTURE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_count_q    <= '0;
			captured_period_q <= '0;
			applied_capture_q <= '0;
			idle_ticks_q      <= '0;
			overlong_q        <= 1'b0;
			prev_level_q      <= 1'b0;
			active_period_q   <= RST_ACTIVE_PERIOD;
			active_high_q     <= RST_ACTIVE_HIGH;
			pending_period_q  <= '0;
			pending_high_q    <= '0;
			pending_valid_q   <= 1'b0;
			wave_count_q      <= '0;
		end else if (accept) begin
			period_count_q    <= count_next;
			captured_period_q <= cap_next;
			idle_ticks_q      <= idle_next;
			overlong_q        <= overlong_next;
			prev_level_q      <= in_ch.sensor_level;
			if (stopped) begin
				// hold pending values, park the wave
				wave_count_q <= '0;
			end else begin
				applied_capture_q <= cap_next;
				if (wrap) begin
					wave_count_q <= '0;
					if (pend_valid_n) begin
						active_period_q <= pend_period_n;
						active_high_q   <= pend_high_n;
					end
					pending_valid_q <= 1'b0;
				end else begin
					wave_count_q    <= wave_count_q + period_t'(1);
					pending_valid_q <= pend_valid_n;
				end
				pending_period_q <= pend_period_n;
				pending_high_q   <= pend_high_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pulse_q     <= 1'b0;
			running_q   <= 1'b0;
			measured_q  <= '0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
			pulse_q     <= pulse_n;
			running_q   <= !stopped;
			measured_q  <= cap_next;
		end else if (out_ch.ready) begin
			// drop the beat once taken
			out_valid_q <= 1'b0;
		end
	end

	assign out_ch.valid           = out_valid_q;
	assign out_ch.pulse_out       = pulse_q;
	assign out_ch.running         = running_q;
	assign out_ch.measured_period = measured_q;

	// ---- checks ----
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ch.ready |-> !in_ch.ready)
		else $error("input taken while result stalled");

	a_low_when_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !running_q |-> !pulse_q)
		else $error("pulse high while stopped");

	a_wave_in_period: assert property (@(posedge clk) disable iff (!arst_n)
		wave_count_q < active_period_q)
		else $error("wave counter beyond active period");

	a_high_within_period: assert property (@(posedge clk) disable iff (!arst_n)
		active_period_q > period_t'(1) && active_high_q <= active_period_q)
		else $error("active high time exceeds period");

	a_pending_sane: assert property (@(posedge clk) disable iff (!arst_n)
		pending_valid_q |-> pending_period_q > period_t'(1))
		else $error("pending period too short");

endmodule
